// ===== sv/minimum_spanning_tree_engine_assert.svh =====
// Assertion macros shared by the minimum spanning tree engine.
`ifndef MINIMUM_SPANNING_TREE_ENGINE_ASSERT_SVH
`define MINIMUM_SPANNING_TREE_ENGINE_ASSERT_SVH

// The condition must never hold once out of reset.
`define MST_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define MST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/mst_pkg.sv =====
package mst_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_NODES_DEF   = 1024;
  localparam int MAX_EDGES_DEF   = 4096;
  localparam int WEIGHT_BITS_DEF = 20;

  // Fixed field widths of the channels.
  localparam int NODE_W  = 10;
  localparam int W_W     = 20;
  localparam int TOTAL_W = 30;
  localparam int CFG_W   = 11;

  // One edge as it travels along the sorting chain.
  typedef struct packed {
    logic              v;
    logic [W_W-1:0]    w;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
  } edge_t;

endpackage

// ===== sv/minimum_spanning_tree_engine.sv =====
// Minimum spanning tree engine (Kruskal).
// Edges arrive on the in_ channel, one beat per edge, one beat per cycle while
// the block is loading; in_last_edge marks the final beat of a graph. Each edge
// enters a row of MAX_EDGES sorting cells, which keep the edges ordered by
// weight as they ripple along. After the last beat the block settles while the
// union-find parent memory is set to identity, then pops edges from the head of
// the row one at a time. Each popped edge is followed by parent-memory reads,
// one at a time, walking to the two roots; the single read port of that memory
// sets the rate. One result beat per graph appears on the out_ channel; in_ready
// is low from the last beat until the result has entered the output register.
// A stalled receiver holds the result in the output register; loading of the
// next graph carries on meanwhile, and the next result waits for the register.
// cfg_wr_data sets the node count and must be written only while idle; the
// block itself does not enforce this.
// Reset (rst_n low, synchronous) empties the row and sets the node count to 1;
// the parent memory needs no clearing pass as each run initialises it.
`include "minimum_spanning_tree_engine_assert.svh"

module minimum_spanning_tree_engine #(
  parameter int MAX_NODES   = mst_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES   = mst_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = mst_pkg::WEIGHT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [mst_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_carries_edge,
  input  logic [mst_pkg::NODE_W-1:0]  in_from_node,
  input  logic [mst_pkg::NODE_W-1:0]  in_to_node,
  input  logic [mst_pkg::W_W-1:0]     in_edge_weight,
  input  logic                        in_last_edge,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_connected,
  output logic [mst_pkg::TOTAL_W-1:0] out_tree_weight,
  output logic [mst_pkg::W_W-1:0]     out_largest_tree_edge,
  output logic                        out_edges_dropped
);

  localparam int NA  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int FCW = $clog2(MAX_EDGES + 1);
  localparam int CW  = ((NCW > FCW) ? NCW : FCW) + 1;
  localparam int W_W = mst_pkg::W_W;
  localparam int T_W = mst_pkg::TOTAL_W;
  localparam logic [W_W-1:0] WMASK =
    (WEIGHT_BITS >= W_W) ? {W_W{1'b1}} : W_W'((64'd1 << WEIGHT_BITS) - 64'd1);

  typedef enum logic [2:0] {
    S_LOAD, S_SETTLE, S_POP, S_CHK_A, S_CHK_B, S_RESULT
  } state_t;

  state_t                   state_r;
  logic [mst_pkg::CFG_W-1:0] cfg_r;
  logic [FCW-1:0]           fill_r;
  logic [FCW-1:0]           pop_cnt_r;
  logic                     ovf_r;
  logic [CW-1:0]            cnt_r;
  mst_pkg::edge_t           e_r;
  logic [NA-1:0]            v_r;
  logic [NA-1:0]            ra_r;
  logic [NCW-1:0]           tc_r;
  logic [T_W-1:0]           total_r;
  logic [W_W-1:0]           max_r;
  logic                     out_valid_r;
  logic                     out_conn_r;
  logic [T_W-1:0]           out_total_r;
  logic [W_W-1:0]           out_max_r;
  logic                     out_drop_r;

  logic [NCW-1:0] n_eff;
  logic           acc;
  logic           in_range;
  logic           store_full;
  logic           ins;
  logic           pop;
  mst_pkg::edge_t ins_edge;
  mst_pkg::edge_t carry_w [MAX_EDGES+1];
  mst_pkg::edge_t held_w  [MAX_EDGES+1];

  logic          wr_en;
  logic [NA-1:0] wr_addr;
  logic [NA-1:0] wr_data;
  logic [NA-1:0] rd_addr;
  logic [NA-1:0] rd_data;
  logic          settle_done;
  logic          join_a;
  logic [T_W:0]  sum_ext;
  logic [T_W-1:0] total_sat;

  // Effective node count: zero acts as one, large values clip to capacity.
  always_comb begin
    if (cfg_r == '0) begin
      n_eff = NCW'(1);
    end else if (32'(cfg_r) > 32'(MAX_NODES)) begin
      n_eff = NCW'(MAX_NODES);
    end else begin
      n_eff = NCW'(cfg_r);
    end
  end

  // Input beat handling.
  assign in_ready   = (state_r == S_LOAD);
  assign acc        = in_valid && in_ready;
  assign in_range   = (32'(in_from_node) < 32'(n_eff)) && (32'(in_to_node) < 32'(n_eff));
  assign store_full = (fill_r == FCW'(MAX_EDGES));
  assign ins        = acc && in_carries_edge && in_range && !store_full;

  always_comb begin
    ins_edge.v = ins;
    ins_edge.w = in_edge_weight & WMASK;
    ins_edge.a = in_from_node;
    ins_edge.b = in_to_node;
  end

  // Sorting row.
  assign pop                = (state_r == S_POP);
  assign carry_w[0]         = ins_edge;
  assign held_w[MAX_EDGES]  = '0;

  for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
    mst_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .pop       (pop),
      .carry_in  (carry_w[i]),
      .next_held (held_w[i+1]),
      .carry_out (carry_w[i+1]),
      .held      (held_w[i])
    );
  end

  // Union-find parent memory.
  mst_ram #(
    .WIDTH (NA),
    .DEPTH (MAX_NODES)
  ) u_parent (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Parent memory port steering.
  assign settle_done = (cnt_r >= CW'(n_eff)) && (cnt_r > CW'(fill_r));
  assign join_a      = (rd_data == v_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = NA'(cnt_r);
    wr_data = NA'(cnt_r);
    rd_addr = rd_data;
    case (state_r)
      S_SETTLE: begin
        wr_en = (cnt_r < CW'(n_eff));
      end
      S_POP: begin
        rd_addr = NA'(held_w[0].a);
      end
      S_CHK_A: begin
        rd_addr = join_a ? NA'(e_r.b) : rd_data;
      end
      S_CHK_B: begin
        wr_en   = join_a && (ra_r != v_r);
        wr_addr = ra_r;
        wr_data = v_r;
      end
      default: begin
        rd_addr = rd_data;
      end
    endcase
  end

  // Saturating tree weight.
  assign sum_ext   = {1'b0, total_r} + (T_W+1)'(e_r.w);
  assign total_sat = sum_ext[T_W] ? {T_W{1'b1}} : sum_ext[T_W-1:0];

  // Sequencer: load, settle and initialise, then one edge at a time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cfg_r       <= mst_pkg::CFG_W'(1);
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      tc_r        <= '0;
      total_r     <= '0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      // The result state reloads the register itself when the old beat leaves.
      if (out_valid_r && out_ready && (state_r != S_RESULT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (acc) begin
            if (ins) begin
              fill_r <= fill_r + FCW'(1);
            end
            if (in_carries_edge && in_range && store_full) begin
              ovf_r <= 1'b1;
            end
            if (in_last_edge) begin
              cnt_r   <= '0;
              state_r <= S_SETTLE;
            end
          end
        end
        S_SETTLE: begin
          cnt_r <= cnt_r + CW'(1);
          if (settle_done) begin
            tc_r      <= '0;
            total_r   <= '0;
            max_r     <= '0;
            pop_cnt_r <= '0;
            state_r   <= (fill_r == '0) ? S_RESULT : S_POP;
          end
        end
        S_POP: begin
          e_r       <= held_w[0];
          v_r       <= NA'(held_w[0].a);
          pop_cnt_r <= pop_cnt_r + FCW'(1);
          state_r   <= S_CHK_A;
        end
        S_CHK_A: begin
          if (join_a) begin
            ra_r    <= v_r;
            v_r     <= NA'(e_r.b);
            state_r <= S_CHK_B;
          end else begin
            v_r <= rd_data;
          end
        end
        S_CHK_B: begin
          if (join_a) begin
            if (ra_r != v_r) begin
              tc_r    <= tc_r + NCW'(1);
              total_r <= total_sat;
              if (e_r.w > max_r) begin
                max_r <= e_r.w;
              end
            end
            state_r <= (pop_cnt_r == fill_r) ? S_RESULT : S_POP;
          end else begin
            v_r <= rd_data;
          end
        end
        S_RESULT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_conn_r  <= (tc_r == n_eff - NCW'(1));
            out_total_r <= (tc_r == n_eff - NCW'(1)) ? total_r : '0;
            out_max_r   <= max_r;
            out_drop_r  <= ovf_r;
            fill_r      <= '0;
            ovf_r       <= 1'b0;
            state_r     <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_connected         = out_conn_r;
  assign out_tree_weight       = out_total_r;
  assign out_largest_tree_edge = out_max_r;
  assign out_edges_dropped     = out_drop_r;

  // Checks on the sequencer and the sorting row.
  `MST_ASSERT_NEVER(a_row_spill, clk, rst_n, carry_w[MAX_EDGES].v, "edge fell off the row")
  `MST_ASSERT_NEVER(a_fill_range, clk, rst_n, 32'(fill_r) > 32'(MAX_EDGES), "fill out of range")
  `MST_ASSERT_IMPL(a_pop_valid, clk, rst_n, pop, held_w[0].v, "popped an empty cell")
  `MST_ASSERT_IMPL(a_wr_busy, clk, rst_n, wr_en, state_r != S_LOAD, "parent write while loading")

endmodule

// ===== sv/mst_ram.sv =====
module mst_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/mst_cell.sv =====
module mst_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop,
  input  mst_pkg::edge_t carry_in,
  input  mst_pkg::edge_t next_held,
  output mst_pkg::edge_t carry_out,
  output mst_pkg::edge_t held
);

  mst_pkg::edge_t held_r, held_nxt;
  mst_pkg::edge_t carry_r, carry_nxt;

  // Keep the lighter of the held and the arriving edge, pass the heavier on.
  // On a tie the arriving edge moves on, so earlier edges stay in front.
  // A pop shifts the whole row one place towards the head.
  always_comb begin
    held_nxt    = held_r;
    carry_nxt   = carry_in;
    carry_nxt.v = 1'b0;
    if (pop) begin
      held_nxt = next_held;
    end else if (carry_in.v) begin
      if (!held_r.v) begin
        held_nxt = carry_in;
      end else if (carry_in.w < held_r.w) begin
        held_nxt  = carry_in;
        carry_nxt = held_r;
      end else begin
        carry_nxt = carry_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      carry_r <= '0;
    end else begin
      held_r  <= held_nxt;
      carry_r <= carry_nxt;
    end
  end

  assign carry_out = carry_r;
  assign held      = held_r;

endmodule
